FILE: rtl/core/wred_pkg.sv
// Package for the weighted random entry draw block.
// Holds codes, field widths, controller state and command/status structs.
// No dependencies.
`default_nettype none

package wred_pkg;

  // Parameter defaults
  localparam int MAX_ENTRIES_DEF = 256;
  localparam int WEIGHT_BITS_DEF = 16;

  // Fixed field widths
  localparam int OP_W     = 2;
  localparam int NODE_W   = 16;
  localparam int INW_W    = 16;
  localparam int RAND_W   = 16;
  localparam int STATUS_W = 3;
  localparam int IDX_W    = 8;
  localparam int KIND_W   = 2;
  localparam int TOTAL_W  = 24;
  localparam int PROD_W   = TOTAL_W + RAND_W;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  // Operation codes
  localparam logic [OP_W-1:0] OP_ADD_SOLO = 2'd0;
  localparam logic [OP_W-1:0] OP_ADD_PAIR = 2'd1;
  localparam logic [OP_W-1:0] OP_DRAW     = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_ADDED    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_DRAWN    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_MISMATCH = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd4;

  // Group kinds
  localparam logic [KIND_W-1:0] KIND_UNDEF = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SOLO  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_PAIR  = 2'd2;

  // Controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_WALK,
    S_RESULT
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic take_item;  // input beat accepted
    logic mul;        // target product ready, issue first read
    logic walk;       // table walk cycle
    logic load_out;   // move pending result into output register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic no_entries;
    logic walk_done;
  } sts_t;

endpackage

`default_nettype wire

FILE: rtl/core/wred_ctrl.sv
// Controller state machine for the weighted random entry draw block.
// Sequences accept, target multiply, table walk and result hand-off.
// Depends on wred_pkg.
`default_nettype none

module wred_ctrl
  import wred_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire logic [OP_W-1:0] opcode,
  output logic                 out_valid,
  input  wire logic            out_ready,
  input  wire sts_t            sts,
  output cmd_t                 cmd
);

  state_t state, state_next;
  logic   out_valid_next;
  logic   in_take;
  logic   slot_free;

  assign in_take   = in_valid && in_ready;
  assign slot_free = !out_valid || out_ready;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_take) begin
          if (opcode == OP_ADD_SOLO || opcode == OP_ADD_PAIR) begin
            state_next = S_RESULT;
          end else if (opcode == OP_DRAW) begin
            state_next = sts.no_entries ? S_RESULT : S_MUL;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      S_MUL:    state_next = S_WALK;
      S_WALK: begin
        if (sts.walk_done) state_next = S_RESULT;
      end
      S_RESULT: begin
        if (slot_free) state_next = S_IDLE;
      end
      default:  state_next = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready     = 1'b0;
    cmd          = '0;
    case (state)
      S_IDLE: begin
        in_ready      = 1'b1;
        cmd.take_item = in_valid;
      end
      S_MUL:    cmd.mul = 1'b1;
      S_WALK:   cmd.walk = 1'b1;
      S_RESULT: cmd.load_out = slot_free;
      default:  cmd = '0;
    endcase
  end

  // Output beat valid
  always_comb begin
    if (cmd.load_out) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/wred_dp.sv
// Datapath for the weighted random entry draw block: entry tables,
// count, saturating total, kind register, target multiply and walk.
// Depends on wred_pkg.
`default_nettype none

module wred_dp
  import wred_pkg::*;
#(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
  parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire cmd_t                cmd,
  output sts_t                     sts,
  input  wire logic [OP_W-1:0]     opcode,
  input  wire logic [NODE_W-1:0]   in_start,
  input  wire logic [NODE_W-1:0]   in_goal,
  input  wire logic [INW_W-1:0]    in_weight,
  input  wire logic [RAND_W-1:0]   random_fraction,
  output logic [STATUS_W-1:0]      status,
  output logic [NODE_W-1:0]        out_start,
  output logic [NODE_W-1:0]        out_goal,
  output logic [IDX_W-1:0]         picked_index,
  output logic [KIND_W-1:0]        group_kind
);

  // Stored weight width: input is masked to WEIGHT_BITS
  localparam int SW = (WEIGHT_BITS < INW_W) ? WEIGHT_BITS : INW_W;
  localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW = $clog2(MAX_ENTRIES + 1);

  // Entry tables
  logic [SW-1:0]     weight_mem [MAX_ENTRIES];
  logic [NODE_W-1:0] start_mem  [MAX_ENTRIES];
  logic [NODE_W-1:0] goal_mem   [MAX_ENTRIES];

  logic [CW-1:0]      entry_count;
  logic [TOTAL_W-1:0] weight_total;
  logic [KIND_W-1:0]  kind_reg;

  logic [PROD_W-1:0]  prod;
  logic [TOTAL_W-1:0] target;
  logic [IW-1:0]      scan_addr;
  logic [IW-1:0]      rd_idx;
  logic [SW-1:0]      rd_w;
  logic [NODE_W-1:0]  rd_start;
  logic [NODE_W-1:0]  rd_goal;

  logic [STATUS_W-1:0] pend_status;
  logic [IW-1:0]       pend_index;
  logic [NODE_W-1:0]   pend_start;
  logic [NODE_W-1:0]   pend_goal;

  logic               is_add;
  logic               full;
  logic [KIND_W-1:0]  add_kind;
  logic [SW-1:0]      add_w;
  logic [IW-1:0]      wr_addr;
  logic [TOTAL_W:0]   sum;
  logic [TOTAL_W-1:0] rd_w_ext;
  logic               hit;
  logic               last;
  logic               do_write;
  logic               re;
  logic [IW-1:0]      raddr;

  assign is_add   = (opcode == OP_ADD_SOLO) || (opcode == OP_ADD_PAIR);
  assign full     = (entry_count == CW'(MAX_ENTRIES));
  assign add_kind = (opcode == OP_ADD_PAIR) ? KIND_PAIR : KIND_SOLO;
  assign add_w    = in_weight[SW-1:0];
  assign wr_addr  = entry_count[IW-1:0];
  assign do_write = cmd.take_item && is_add && !full;
  assign sum      = {1'b0, weight_total} + (TOTAL_W + 1)'(add_w);

  // Walk compare: one stored weight per cycle
  assign rd_w_ext = TOTAL_W'(rd_w);
  assign hit      = (target <= rd_w_ext);
  assign last     = (rd_idx == IW'(entry_count - CW'(1)));

  assign sts.no_entries = (entry_count == '0);
  assign sts.walk_done  = cmd.walk && (hit || last);

  // Read port: scan address, used from the multiply cycle on
  assign re    = cmd.mul || cmd.walk;
  assign raddr = scan_addr;

  // Table memories, one write and one registered read port each
  always_ff @(posedge clk) begin
    if (do_write) begin
      weight_mem[wr_addr] <= add_w;
      start_mem[wr_addr]  <= in_start;
      goal_mem[wr_addr]   <= (opcode == OP_ADD_PAIR) ? in_goal : '0;
    end
    if (re) begin
      rd_w     <= weight_mem[raddr];
      rd_start <= start_mem[raddr];
      rd_goal  <= goal_mem[raddr];
    end
  end

  // Table control state
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count  <= '0;
      weight_total <= '0;
      kind_reg     <= KIND_UNDEF;
    end else if (do_write) begin
      entry_count  <= entry_count + CW'(1);
      weight_total <= sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];
      if (kind_reg == KIND_UNDEF) kind_reg <= add_kind;
    end
  end

  // Target multiply, walk and pending result
  always_ff @(posedge clk) begin
    if (cmd.take_item) begin
      prod       <= PROD_W'(weight_total) * PROD_W'(random_fraction);
      scan_addr  <= '0;
      pend_start <= '0;
      pend_goal  <= '0;
      pend_index <= '0;
      if (is_add) begin
        if (full) begin
          pend_status <= ST_FULL;
        end else begin
          pend_index  <= wr_addr;
          pend_status <= (kind_reg != KIND_UNDEF && kind_reg != add_kind) ?
                         ST_MISMATCH : ST_ADDED;
        end
      end else begin
        pend_status <= (entry_count == '0) ? ST_EMPTY : ST_DRAWN;
      end
    end
    if (cmd.mul) begin
      target <= prod[PROD_W-1:RAND_W];
    end
    if (re) begin
      rd_idx    <= scan_addr;
      scan_addr <= scan_addr + IW'(1);
    end
    if (cmd.walk) begin
      // entry 0 is the fallback, a hit overrides it
      if (hit || rd_idx == '0) begin
        pend_index <= rd_idx;
        pend_start <= rd_start;
        pend_goal  <= (kind_reg == KIND_SOLO) ? '0 : rd_goal;
      end
      if (!hit) target <= target - rd_w_ext;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      status       <= pend_status;
      out_start    <= pend_start;
      out_goal     <= pend_goal;
      picked_index <= IDX_W'(pend_index);
      group_kind   <= kind_reg;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/weighted_random_entry_draw.sv
// Weighted random entry draw: add beats and empty draws go from accept
// straight to the result state. Draw beats pass the multiply state, then a
// walk reading one stored weight per cycle until a hit or the last entry;
// entry 0 is picked if none hits. One beat is in flight at a time; the
// result is loaded once the output slot is free; the next beat is accepted
// in the cycle after the load. Synchronous reset clears count, total, kind
// and controller; tables are not cleared. Uses wred_pkg, wred_ctrl, wred_dp.
`default_nettype none

module weighted_random_entry_draw
  import wred_pkg::*;
#(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
  parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [OP_W-1:0]     opcode,
  input  wire logic [NODE_W-1:0]   in_start,
  input  wire logic [NODE_W-1:0]   in_goal,
  input  wire logic [INW_W-1:0]    in_weight,
  input  wire logic [RAND_W-1:0]   random_fraction,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [STATUS_W-1:0]      status,
  output logic [NODE_W-1:0]        out_start,
  output logic [NODE_W-1:0]        out_goal,
  output logic [IDX_W-1:0]         picked_index,
  output logic [KIND_W-1:0]        group_kind
);

  cmd_t cmd;
  sts_t sts;

  wred_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .opcode    (opcode),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  wred_dp #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sts             (sts),
    .opcode          (opcode),
    .in_start        (in_start),
    .in_goal         (in_goal),
    .in_weight       (in_weight),
    .random_fraction (random_fraction),
    .status          (status),
    .out_start       (out_start),
    .out_goal        (out_goal),
    .picked_index    (picked_index),
    .group_kind      (group_kind)
  );

endmodule

`default_nettype wire
